FILE: rtl/bcc_pkg.sv
// shared types and constants for the battery coulomb counter
package bcc_pkg;
    localparam int unsigned CapThresholdAs = 18000;
    localparam int unsigned CapRampAs      = 360;
    localparam int unsigned PeriodMs       = 100;
    localparam int unsigned DwellMs        = 5000;
    localparam int unsigned VoltMarginMv   = 50;
    localparam logic [15:0] InvalidCurrent = 16'h7fff;

    localparam logic [1:0] REG_TOTAL  = 2'd0;
    localparam logic [1:0] REG_ACTUAL = 2'd1;
    localparam logic [1:0] REG_VMAX   = 2'd2;
    localparam logic [1:0] REG_VMIN   = 2'd3;

    typedef struct packed {
        logic load;      // latch request and advance clock
        logic init;      // init item
        logic invalid;   // invalid current item
        logic estimate;  // run capacity estimation
        logic div_start; // start soc division
        logic count;     // integrate and count, store soc
    } bcc_cmd_t;

    typedef struct packed {
        logic is_init;
        logic is_invalid;
        logic initialized;
        logic div_busy;
    } bcc_status_t;
endpackage

FILE: rtl/bcc_datapath.sv
// datapath: state registers, estimation, serial soc divider, counting
module bcc_datapath import bcc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  bcc_cmd_t    cmd,
    output bcc_status_t status,
    input  logic [31:0] cfg_total,
    input  logic [31:0] cfg_actual,
    input  logic [15:0] cfg_vmax,
    input  logic [15:0] cfg_vmin,
    input  logic [64:0] req_data,
    output logic [15:0] soc_percent,
    output logic [31:0] total_as,
    output logic [31:0] actual_as,
    output logic [31:0] cycle_energy_as,
    output logic        estimation_done
);
    logic [64:0] req_reg;
    logic [31:0] clock_reg, stamp_reg, low_since_reg, high_since_reg;
    logic [31:0] accum_reg, accum_prev_reg, actual_reg, total_reg, energy_reg;
    logic [15:0] hi_th_reg, lo_th_reg, soc_reg;
    logic        done_reg, init_reg;
    // divider
    logic [38:0] rem_reg;
    logic [38:0] quo_reg;
    logic [5:0]  div_cnt_reg;
    logic        div_busy_reg;

    logic        op;
    logic [15:0] cur, vmax, vmin;
    assign op   = req_reg[0];
    assign cur  = req_reg[32:17];
    assign vmax = req_reg[48:33];
    assign vmin = req_reg[64:49];

    assign status.is_init     = op;
    assign status.is_invalid  = (cur == InvalidCurrent);
    assign status.initialized = init_reg;
    assign status.div_busy    = div_busy_reg;

    logic [31:0] hi_dt, lo_dt, gap_up, gap_dn, tot_sat;
    logic [32:0] tot_sum;
    assign hi_dt   = clock_reg - high_since_reg;
    assign lo_dt   = clock_reg - low_since_reg;
    assign gap_up  = total_reg - actual_reg;
    assign gap_dn  = actual_reg - total_reg;
    assign tot_sum = {1'b0, total_reg} + 33'(CapRampAs);
    assign tot_sat = tot_sum[32] ? 32'hffffffff : tot_sum[31:0];

    logic [31:0] tm, cur32, accum_n, diff;
    assign tm      = clock_reg - stamp_reg;
    assign cur32   = {{16{cur[15]}}, cur};
    assign accum_n = (tm >= 32'(PeriodMs)) ? accum_reg - cur32 : accum_reg;
    assign diff    = accum_n - accum_prev_reg;

    logic [39:0] trial;
    assign trial = {rem_reg, quo_reg[38]} - {8'd0, total_reg};

    logic [38:0] q_fin;
    assign q_fin = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg <= '0; stamp_reg <= '0; low_since_reg <= '0;
            high_since_reg <= '0; accum_reg <= '0; accum_prev_reg <= '0;
            actual_reg <= '0; total_reg <= '0; energy_reg <= '0;
            hi_th_reg <= '0; lo_th_reg <= '0; soc_reg <= '0;
            done_reg <= 1'b0; init_reg <= 1'b0; div_busy_reg <= 1'b0;
            div_cnt_reg <= '0;
        end else begin
            if (cmd.load) begin
                req_reg   <= req_data;
                clock_reg <= clock_reg + {16'd0, req_data[16:1]};
            end
            if (cmd.init) begin
                total_reg  <= cfg_total;
                actual_reg <= cfg_actual;
                hi_th_reg  <= cfg_vmax - 16'(VoltMarginMv);
                lo_th_reg  <= cfg_vmin + 16'(VoltMarginMv);
                init_reg   <= 1'b1;
            end
            if (cmd.invalid) begin
                total_reg <= 32'hffffffff;
                soc_reg   <= 16'hffff;
            end
            if (cmd.estimate) begin
                if (vmax >= hi_th_reg) begin
                    if (!done_reg && hi_dt > 32'(DwellMs)) begin
                        done_reg <= 1'b1;
                        if (total_reg >= actual_reg) begin
                            if (gap_up > 32'(CapThresholdAs) &&
                                total_reg > 32'(CapThresholdAs))
                                total_reg <= total_reg - 32'(CapRampAs);
                        end else if (gap_dn > 32'(CapThresholdAs)) begin
                            total_reg  <= total_reg + 32'(CapRampAs);
                            actual_reg <= total_reg + 32'(CapRampAs);
                        end
                    end
                end else if (vmin <= lo_th_reg) begin
                    if (!done_reg && lo_dt > 32'(DwellMs)) begin
                        if (actual_reg > 32'(CapThresholdAs)) begin
                            done_reg   <= 1'b1;
                            actual_reg <= 32'(CapThresholdAs);
                            total_reg  <= tot_sat;
                        end else if (actual_reg == '0) begin
                            done_reg   <= 1'b1;
                            actual_reg <= 32'(CapThresholdAs);
                            if (total_reg > 32'(CapThresholdAs))
                                total_reg <= total_reg - 32'(CapRampAs);
                        end
                    end
                end else begin
                    low_since_reg  <= clock_reg;
                    high_since_reg <= clock_reg;
                    done_reg       <= 1'b0;
                end
            end
            // restoring division of 100*actual by total, one bit a cycle
            if (cmd.div_start) begin
                rem_reg      <= '0;
                quo_reg      <= 39'({7'd0, actual_reg} * 39'd100);
                div_cnt_reg  <= 6'd39;
                div_busy_reg <= (total_reg != '0);
            end else if (div_busy_reg) begin
                if (!trial[39]) begin
                    rem_reg <= trial[38:0];
                    quo_reg <= {quo_reg[37:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[37:0], quo_reg[38]};
                    quo_reg <= {quo_reg[37:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg - 6'd1;
                if (div_cnt_reg == 6'd1) div_busy_reg <= 1'b0;
            end
            if (cmd.count) begin
                if (total_reg == '0 || q_fin > 39'd100) soc_reg <= 16'd100;
                else soc_reg <= q_fin[15:0];
                if (tm >= 32'(PeriodMs)) begin
                    stamp_reg <= clock_reg - (tm - 32'(PeriodMs));
                    accum_reg <= accum_n;
                end
                if (!diff[31] && diff >= 32'd100) begin
                    energy_reg <= energy_reg + 32'd1;
                    if (actual_reg != 32'hffffffff) actual_reg <= actual_reg + 32'd1;
                    accum_prev_reg <= accum_prev_reg + 32'd100;
                end else if (diff[31] && diff <= 32'hffffff9c) begin
                    energy_reg <= energy_reg - 32'd1;
                    if (actual_reg != '0) actual_reg <= actual_reg - 32'd1;
                    accum_prev_reg <= accum_prev_reg - 32'd100;
                end
            end
        end
    end

    assign soc_percent     = soc_reg;
    assign total_as        = total_reg;
    assign actual_as       = actual_reg;
    assign cycle_energy_as = energy_reg;
    assign estimation_done = done_reg;
endmodule

FILE: rtl/bcc_ctrl.sv
// controller state machine sequencing one request
module bcc_ctrl import bcc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  bcc_status_t status,
    output bcc_cmd_t    cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_EST  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                cmd.load = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC: begin
                priority if (status.is_init) begin
                    cmd.init = 1'b1;
                    state_next = ST_OUT;
                end else if (status.is_invalid) begin
                    cmd.invalid = 1'b1;
                    state_next = ST_OUT;
                end else if (status.initialized) begin
                    cmd.estimate = 1'b1;
                    state_next = ST_EST;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_EST: begin
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: if (!status.div_busy) state_next = ST_WAIT;
            ST_WAIT: begin
                cmd.count = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end
endmodule

FILE: rtl/battery_coulomb_counter.sv
// battery coulomb counter: top level with config registers
// flow: an init, invalid or uninitialised request goes from decode straight to the output
// state; a measure request first passes estimation, the 39-step soc divider (skipped when
// the total is zero) and a wait state
// throughput: one request at a time, the next is taken the cycle after the result leaves
// reset: synchronous active-low aresetn clears counter state and config registers, not the request or divider data
module battery_coulomb_counter import bcc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata, // elapsed_ms, current_deci_amp, max_cell_mv, min_cell_mv
    input  logic        s_tuser, // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [119:0] m_tdata, // soc_percent, total_as, actual_as,
                                  // cycle_energy_as, estimation_done, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [31:0] tot_cfg_reg, act_cfg_reg;
    logic [15:0] vmax_cfg_reg, vmin_cfg_reg;
    bcc_cmd_t    cmd;
    bcc_status_t status;
    logic [15:0] soc;
    logic [31:0] tot, act, energy;
    logic        done;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tot_cfg_reg <= '0; act_cfg_reg <= '0;
            vmax_cfg_reg <= '0; vmin_cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TOTAL:  tot_cfg_reg  <= cfg_data;
                REG_ACTUAL: act_cfg_reg  <= cfg_data;
                REG_VMAX:   vmax_cfg_reg <= cfg_data[15:0];
                REG_VMIN:   vmin_cfg_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    bcc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .status(status), .cmd(cmd)
    );

    bcc_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .cfg_total(tot_cfg_reg), .cfg_actual(act_cfg_reg),
        .cfg_vmax(vmax_cfg_reg), .cfg_vmin(vmin_cfg_reg),
        .req_data({s_tdata, s_tuser}),
        .soc_percent(soc), .total_as(tot), .actual_as(act),
        .cycle_energy_as(energy), .estimation_done(done)
    );

    assign m_tdata = {7'd0, done, energy, act, tot, soc};
endmodule
